// ----- hw/rtl/chdt_pkg.sv -----
// Package: constants, types and state encoding for the canonical Huffman decode table.
`default_nettype none
package chdt_pkg;
  localparam int SYMBOLS_DEF = 256;
  localparam int MAX_LENGTH_DEF = 12;
  localparam int SYM_W = 8;
  localparam int LEN_W = 4;
  localparam int WIN_W = 12;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_COUNT,
    ST_KRAFT,
    ST_FILL_RD,
    ST_FILL_WR
  } state_t;

  typedef struct packed {
    logic           we;
    logic [15:0]    addr;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
  } tbl_wr_t;
endpackage
`default_nettype wire

// ----- hw/rtl/chdt_len_mem.sv -----
// Stored code length memory: one write port, one registered read port.
`default_nettype none
module chdt_len_mem #(
  parameter int SYMBOLS = chdt_pkg::SYMBOLS_DEF,
  parameter int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [chdt_pkg::LEN_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic [chdt_pkg::LEN_W-1:0]     rdata_r
);
  logic [chdt_pkg::LEN_W-1:0] mem [SYMBOLS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/chdt_tbl_mem.sv -----
// Decode table memory: symbol and length per window entry.
`default_nettype none
module chdt_tbl_mem #(
  parameter int MAX_LENGTH = chdt_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                       clk,
  input  wire chdt_pkg::tbl_wr_t          wr,
  input  wire logic [MAX_LENGTH-1:0]      raddr,
  output logic [chdt_pkg::SYM_W-1:0]      rsym_r,
  output logic [chdt_pkg::LEN_W-1:0]      rlen_r
);
  localparam int DEPTH = 1 << MAX_LENGTH;
  logic [chdt_pkg::SYM_W+chdt_pkg::LEN_W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr[MAX_LENGTH-1:0]] <= {wr.sym, wr.len};
    {rsym_r, rlen_r} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/canonical_huffman_decode_table_core.sv -----
// Top level: canonical Huffman decode table with load, build and lookup.
//
// A lookup is accepted when start is high and busy low; its result returns with
// out_valid after the table read register and the output register. Lookups may
// be issued every cycle while busy is low. A load holds busy high while its
// length is written. A load marked last starts a build that holds busy high
// while it clears all 2^MAX_LENGTH table entries, counts the stored lengths and
// forms the Kraft sum, then per length 1..MAX_LENGTH scans the symbols and
// writes 2^(MAX_LENGTH-L) entries per used symbol; a failed build stops after
// the Kraft sum. After reset busy is high while the stored lengths clear, then
// through a build over all-zero lengths. Results cannot be stalled.
`default_nettype none
module canonical_huffman_decode_table_core #(
  parameter int SYMBOLS = chdt_pkg::SYMBOLS_DEF,
  parameter int MAX_LENGTH = chdt_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_req_type,
  input  wire logic [chdt_pkg::SYM_W-1:0]    in_symbol_index,
  input  wire logic [chdt_pkg::LEN_W-1:0]    in_code_length,
  input  wire logic                          in_last_length,
  input  wire logic [chdt_pkg::WIN_W-1:0]    in_code_window,
  output logic                               out_valid,
  output logic [chdt_pkg::SYM_W-1:0]         out_decoded_symbol,
  output logic [chdt_pkg::LEN_W-1:0]         out_decoded_length,
  output logic                               out_table_error
);
  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SCW = AW + 1;
  localparam int DEPTH = 1 << MAX_LENGTH;
  localparam int CW = MAX_LENGTH + 2;
  localparam int KW = SCW + MAX_LENGTH;
  localparam int LW = chdt_pkg::LEN_W + 1;

  chdt_pkg::state_t state_r, state_nxt;
  logic [SCW-1:0] scan_r, scan_nxt;
  logic [LW-1:0] lcur_r, lcur_nxt;
  logic [MAX_LENGTH:0] fill_r, fill_nxt;
  logic [MAX_LENGTH:0] span_r, span_nxt;
  logic [MAX_LENGTH-1:0] base_r, base_nxt;
  logic [CW-1:0] code_r, code_nxt;
  logic [KW-1:0] kraft_r, kraft_nxt;
  logic [SCW-1:0] cnt_r [MAX_LENGTH+1];
  logic [SCW-1:0] cnt_nxt [MAX_LENGTH+1];
  logic [CW-1:0] nc_r [MAX_LENGTH+1];
  logic [CW-1:0] nc_nxt [MAX_LENGTH+1];
  logic err_r, err_nxt;
  logic rd_pend_r, rv_r;
  logic load_pend_r;
  logic last_pend_r;
  logic [AW-1:0] lw_addr_r;
  logic [chdt_pkg::LEN_W-1:0] lw_len_r;
  logic lw_ok_r;
  logic lm_we;
  logic [AW-1:0] lm_waddr;
  logic [chdt_pkg::LEN_W-1:0] lm_wdata;
  logic [AW-1:0] len_raddr;
  logic [chdt_pkg::LEN_W-1:0] len_rdata;
  logic [SCW-1:0] rd_idx_r;
  chdt_pkg::tbl_wr_t wr;
  logic [chdt_pkg::SYM_W-1:0] tsym;
  logic [chdt_pkg::LEN_W-1:0] tlen;
  logic acc;
  logic scan_done;

  assign acc = start && !busy;
  assign busy = (state_r != chdt_pkg::ST_IDLE) || load_pend_r;

  assign lm_we = lw_ok_r || (state_r == chdt_pkg::ST_INIT);
  assign lm_waddr = (state_r == chdt_pkg::ST_INIT) ? scan_r[AW-1:0] : lw_addr_r;
  assign lm_wdata = (state_r == chdt_pkg::ST_INIT) ? '0 : lw_len_r;

  chdt_len_mem #(.SYMBOLS(SYMBOLS), .AW(AW)) u_len (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(len_raddr), .rdata_r(len_rdata)
  );

  chdt_tbl_mem #(.MAX_LENGTH(MAX_LENGTH)) u_tbl (
    .clk(clk), .wr(wr), .raddr(in_code_window[MAX_LENGTH-1:0]),
    .rsym_r(tsym), .rlen_r(tlen)
  );

  assign len_raddr = scan_r[AW-1:0];
  assign scan_done = (scan_r == SCW'(SYMBOLS));

  always_ff @(posedge clk) begin
    lw_addr_r <= in_symbol_index[AW-1:0];
    lw_len_r <= in_code_length;
    rd_idx_r <= scan_r;
    if (!rst_n) begin
      state_r <= chdt_pkg::ST_INIT;
      scan_r <= '0;
      fill_r <= '0;
      err_r <= 1'b0;
      rd_pend_r <= 1'b0;
      rv_r <= 1'b0;
      load_pend_r <= 1'b0;
      last_pend_r <= 1'b0;
      lw_ok_r <= 1'b0;
      lcur_r <= '0;
      span_r <= '0;
      base_r <= '0;
      code_r <= '0;
      kraft_r <= '0;
      for (int i = 0; i <= MAX_LENGTH; i++) begin
        cnt_r[i] <= '0;
        nc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      scan_r <= scan_nxt;
      fill_r <= fill_nxt;
      err_r <= err_nxt;
      lcur_r <= lcur_nxt;
      span_r <= span_nxt;
      base_r <= base_nxt;
      code_r <= code_nxt;
      kraft_r <= kraft_nxt;
      for (int i = 0; i <= MAX_LENGTH; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        nc_r[i] <= nc_nxt[i];
      end
      rd_pend_r <= acc && in_req_type == chdt_pkg::REQ_LOOKUP;
      rv_r <= rd_pend_r;
      load_pend_r <= acc && in_req_type == chdt_pkg::REQ_LOAD;
      last_pend_r <= acc && in_req_type == chdt_pkg::REQ_LOAD && in_last_length;
      lw_ok_r <= acc && in_req_type == chdt_pkg::REQ_LOAD &&
                 ({8'd0, in_symbol_index} < 16'(SYMBOLS));
    end
  end

  always_ff @(posedge clk) begin
    out_decoded_symbol <= tsym;
    out_decoded_length <= tlen;
    out_table_error <= err_r;
  end
  assign out_valid = rv_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt = scan_r;
    fill_nxt = fill_r;
    err_nxt = err_r;
    lcur_nxt = lcur_r;
    span_nxt = span_r;
    base_nxt = base_r;
    code_nxt = code_r;
    kraft_nxt = kraft_r;
    for (int i = 0; i <= MAX_LENGTH; i++) begin
      cnt_nxt[i] = cnt_r[i];
      nc_nxt[i] = nc_r[i];
    end
    wr.we = 1'b0;
    wr.addr = 16'(fill_r[MAX_LENGTH-1:0]);
    wr.sym = '0;
    wr.len = '0;
    case (state_r)
      chdt_pkg::ST_IDLE: begin
        if (last_pend_r) begin
          state_nxt = chdt_pkg::ST_CLEAR;
          fill_nxt = '0;
          err_nxt = 1'b0;
          for (int i = 0; i <= MAX_LENGTH; i++) begin
            cnt_nxt[i] = '0;
            nc_nxt[i] = '0;
          end
        end
      end
      chdt_pkg::ST_INIT: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == SCW'(SYMBOLS - 1)) begin
          state_nxt = chdt_pkg::ST_CLEAR;
          fill_nxt = '0;
        end
      end
      chdt_pkg::ST_CLEAR: begin
        wr.we = 1'b1;
        fill_nxt = fill_r + 1'b1;
        scan_nxt = '0;
        if (fill_r == (MAX_LENGTH+1)'(DEPTH - 1)) begin
          state_nxt = chdt_pkg::ST_COUNT;
        end
      end
      chdt_pkg::ST_COUNT: begin
        if (scan_r != '0) begin
          if (len_rdata != '0) begin
            if (LW'(len_rdata) > LW'(MAX_LENGTH)) err_nxt = 1'b1;
            else cnt_nxt[len_rdata] = cnt_r[len_rdata] + 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = chdt_pkg::ST_KRAFT;
          lcur_nxt = LW'(1);
          kraft_nxt = '0;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      chdt_pkg::ST_KRAFT: begin
        if (lcur_r <= LW'(MAX_LENGTH)) begin
          kraft_nxt = kraft_r +
            (KW'(cnt_r[lcur_r[chdt_pkg::LEN_W-1:0]]) << (LW'(MAX_LENGTH) - lcur_r));
          if (lcur_r >= LW'(2)) begin
            nc_nxt[lcur_r[chdt_pkg::LEN_W-1:0]] =
              CW'((nc_r[lcur_r[chdt_pkg::LEN_W-1:0]-1'b1] +
                   CW'(cnt_r[lcur_r[chdt_pkg::LEN_W-1:0]-1'b1])) << 1);
          end
          lcur_nxt = lcur_r + 1'b1;
        end else begin
          if (kraft_r > KW'(DEPTH)) err_nxt = 1'b1;
          if (err_r || kraft_r > KW'(DEPTH)) begin
            state_nxt = chdt_pkg::ST_IDLE;
            lcur_nxt = '0;
          end else begin
            state_nxt = chdt_pkg::ST_FILL_RD;
            lcur_nxt = LW'(1);
            code_nxt = nc_r[1];
            scan_nxt = '0;
          end
        end
      end
      chdt_pkg::ST_FILL_RD: begin
        if (scan_r != '0 && len_rdata != '0 &&
            LW'(len_rdata) == lcur_r) begin
          state_nxt = chdt_pkg::ST_FILL_WR;
          span_nxt = (MAX_LENGTH+1)'(1) << (LW'(MAX_LENGTH) - lcur_r);
          base_nxt = MAX_LENGTH'(code_r << (LW'(MAX_LENGTH) - lcur_r));
          fill_nxt = '0;
          code_nxt = code_r + 1'b1;
        end else if (scan_done) begin
          if (lcur_r == LW'(MAX_LENGTH)) begin
            state_nxt = chdt_pkg::ST_IDLE;
            lcur_nxt = '0;
          end else begin
            lcur_nxt = lcur_r + 1'b1;
            code_nxt = nc_r[lcur_r[chdt_pkg::LEN_W-1:0]+1'b1];
            scan_nxt = '0;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      chdt_pkg::ST_FILL_WR: begin
        wr.we = 1'b1;
        wr.addr = 16'(base_r + fill_r[MAX_LENGTH-1:0]);
        wr.sym = chdt_pkg::SYM_W'(rd_idx_r - 1'b1);
        wr.len = lcur_r[chdt_pkg::LEN_W-1:0];
        fill_nxt = fill_r + 1'b1;
        if (fill_r + 1'b1 == span_r) begin
          state_nxt = chdt_pkg::ST_FILL_RD;
          if (scan_done) begin
            if (lcur_r == LW'(MAX_LENGTH)) begin
              state_nxt = chdt_pkg::ST_IDLE;
              lcur_nxt = '0;
            end else begin
              lcur_nxt = lcur_r + 1'b1;
              code_nxt = nc_r[lcur_r[chdt_pkg::LEN_W-1:0]+1'b1];
              scan_nxt = '0;
            end
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      default: state_nxt = chdt_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/chdt_checker.sv -----
// Port-level checker for the decode table core, bound to the top level.
`default_nettype none
module chdt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_req_type,
  input wire logic out_valid,
  input wire logic [chdt_pkg::LEN_W-1:0] out_decoded_length,
  input wire logic out_table_error
);
  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == chdt_pkg::REQ_LOOKUP) |-> ##2 out_valid)
    else $error("lookup lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_req_type == chdt_pkg::REQ_LOOKUP, 2))
    else $error("spurious result");
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_error) |-> out_decoded_length == '0)
    else $error("error with code");
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == chdt_pkg::REQ_LOAD) |=> busy)
    else $error("load not held");
endmodule

bind canonical_huffman_decode_table_core chdt_checker u_chdt_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req_type(in_req_type),
  .out_valid(out_valid), .out_decoded_length(out_decoded_length),
  .out_table_error(out_table_error)
);
`default_nettype wire

// ----- test/canonical_huffman_decode_table_core_test.sv -----
// Testbench for the canonical Huffman decode table: loads, builds and checked lookups.
`default_nettype none
module canonical_huffman_decode_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = chdt_pkg::SYM_W;
  localparam int LW = chdt_pkg::LEN_W;
  localparam int WW = chdt_pkg::WIN_W;
  localparam int NSYM = 256;
  localparam int MAXL = 12;
  localparam int TSIZE = 1 << MAXL;

  typedef struct packed {
    logic [SW-1:0] sym;
    logic [LW-1:0] len;
    logic          err;
  } decode_t;

  class decode_scoreboard;
    logic [LW-1:0] lengths [NSYM];
    logic [SW-1:0] tbl_sym [TSIZE];
    logic [LW-1:0] tbl_len [TSIZE];
    logic          err;
    decode_t       pending [$];
    int            fails;

    function void clear_table();
      foreach (tbl_sym[i]) begin
        tbl_sym[i] = '0;
        tbl_len[i] = '0;
      end
    endfunction

    function void reset();
      foreach (lengths[i]) lengths[i] = '0;
      clear_table();
      err = 1'b0;
      pending.delete();
      fails = 0;
    endfunction

    function void build();
      int cnt [MAXL+1];
      int code [MAXL+1];
      int kraft, first, span;
      clear_table();
      err = 1'b0;
      kraft = 0;
      foreach (cnt[i]) begin
        cnt[i] = 0;
        code[i] = 0;
      end
      for (int s = 0; s < NSYM; s++) begin
        if (lengths[s] > MAXL) err = 1'b1;
        else if (lengths[s] != 0) cnt[lengths[s]]++;
      end
      for (int l = 1; l <= MAXL; l++) kraft += cnt[l] << (MAXL - l);
      if (kraft > TSIZE) err = 1'b1;
      if (err) return;
      for (int l = 2; l <= MAXL; l++) code[l] = (code[l-1] + cnt[l-1]) << 1;
      for (int l = 1; l <= MAXL; l++) begin
        span = 1 << (MAXL - l);
        for (int s = 0; s < NSYM; s++) begin
          if (lengths[s] != l) continue;
          first = code[l] << (MAXL - l);
          code[l]++;
          for (int j = 0; j < span; j++) begin
            tbl_sym[(first + j) % TSIZE] = SW'(s);
            tbl_len[(first + j) % TSIZE] = LW'(l);
          end
        end
      end
    endfunction

    function void note_request(logic rt, logic [SW-1:0] s, logic [LW-1:0] l,
                               logic last, logic [WW-1:0] w);
      decode_t d;
      if (rt == chdt_pkg::REQ_LOAD) begin
        lengths[s] = l;
        if (last) build();
      end else begin
        d.sym = tbl_sym[w];
        d.len = tbl_len[w];
        d.err = err;
        pending.push_back(d);
      end
    endfunction

    function void check_result(logic [SW-1:0] s, logic [LW-1:0] l, logic e);
      decode_t d;
      if (pending.size() == 0) begin
        $error("unexpected result sym=%0d len=%0d err=%0d", s, l, e);
        fails++;
        return;
      end
      d = pending.pop_front();
      if (s !== d.sym) begin
        $error("decoded_symbol expected %0d actual %0d", d.sym, s);
        fails++;
      end
      if (l !== d.len) begin
        $error("decoded_length expected %0d actual %0d", d.len, l);
        fails++;
      end
      if (e !== d.err) begin
        $error("table_error expected %0d actual %0d", d.err, e);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [SW-1:0] in_symbol_index = '0;
  logic [LW-1:0] in_code_length = '0;
  logic in_last_length = 1'b0;
  logic [WW-1:0] in_code_window = '0;
  logic out_valid;
  logic [SW-1:0] out_decoded_symbol;
  logic [LW-1:0] out_decoded_length;
  logic out_table_error;
  int sent = 0;

  decode_scoreboard sb = new();

  canonical_huffman_decode_table_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_symbol_index(in_symbol_index),
    .in_code_length(in_code_length), .in_last_length(in_last_length),
    .in_code_window(in_code_window), .out_valid(out_valid),
    .out_decoded_symbol(out_decoded_symbol), .out_decoded_length(out_decoded_length),
    .out_table_error(out_table_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_decoded_symbol, out_decoded_length, out_table_error);
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // hold start until accepted, then drop it unless the next request follows at once
  task automatic send_request(logic rt, logic [SW-1:0] s, logic [LW-1:0] l,
                              logic last, logic [WW-1:0] w);
    start <= 1'b1;
    in_req_type <= rt;
    in_symbol_index <= s;
    in_code_length <= l;
    in_last_length <= last;
    in_code_window <= w;
    do @(posedge clk); while (busy);
    sb.note_request(rt, s, l, last, w);
    sent++;
    if ($urandom_range(0, 2) != 0) begin
      start <= 1'b0;
      @(posedge clk);
      idle_gap();
    end
  endtask

  task automatic lookup(logic [WW-1:0] w);
    send_request(chdt_pkg::REQ_LOOKUP, SW'($urandom), LW'($urandom), 1'($urandom), w);
  endtask

  task automatic load(logic [SW-1:0] s, logic [LW-1:0] l, logic last);
    send_request(chdt_pkg::REQ_LOAD, s, l, last, WW'($urandom));
  endtask

  // random code set: mode 0 picks lengths that keep the Kraft sum at or below one
  task automatic load_code_set(int mode);
    int budget, nsyms, l;
    budget = TSIZE;
    nsyms = $urandom_range(1, 20);
    for (int k = 0; k < nsyms; k++) begin
      l = $urandom_range(1, MAXL);
      if (mode == 0) begin
        while (l <= MAXL && (1 << (MAXL - l)) > budget) l++;
        if (l > MAXL) l = 0;
        else budget -= 1 << (MAXL - l);
      end else if (mode == 1 && k == 0) begin
        l = $urandom_range(MAXL + 1, 15);
      end
      load(SW'($urandom), LW'(l), k == nsyms - 1);
    end
  endtask

  task automatic clear_all();
    for (int s = 0; s < NSYM; s++) load(SW'(s), '0, s == NSYM - 1);
  endtask

  initial begin
    int iter, mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    sb.reset();
    @(posedge clk);

    lookup('0);
    lookup('1);
    load(0, 1, 1'b0);
    load(255, 1, 1'b1);
    lookup(12'h000);
    lookup(12'h800);
    lookup(12'hFFF);
    load(7, 2, 1'b1);
    lookup(12'h800);
    load(7, 15, 1'b1);
    lookup(12'h000);
    load(7, 0, 1'b0);
    load(0, 12, 1'b0);
    load(255, 12, 1'b1);
    lookup(12'h000);
    lookup(12'h001);
    lookup(12'h002);
    load(128, 13, 1'b1);
    lookup(12'hAAA);
    load(128, 0, 1'b1);
    lookup(12'h555);

    iter = 0;
    while (sent < 1950) begin
      if (iter == 6) clear_all();
      mode = $urandom_range(0, 9);
      load_code_set(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 15) == 0) load(SW'($urandom), LW'($urandom), 1'b0);
        else lookup(WW'($urandom));
      end
      iter++;
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fails == 0)
      $display("canonical_huffman_decode_table_core_test OK");
    else
      $display("canonical_huffman_decode_table_core_test NOT OK");
    $finish;
  end

  initial begin
    #400ms;
    $display("canonical_huffman_decode_table_core_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/chdt_pkg.sv
hw/rtl/chdt_len_mem.sv
hw/rtl/chdt_tbl_mem.sv
hw/rtl/canonical_huffman_decode_table_core.sv
hw/rtl/chdt_checker.sv
test/canonical_huffman_decode_table_core_test.sv
